/* rtl/arsd_pkg.sv */
package arsd_pkg;

    localparam int PAL_DEPTH = 256;
    localparam logic [16:0] MAX_FRAME_PIXELS = 17'h10000;
    localparam logic [16:0] FRAME_PIXELS_RST = 17'd64000;
    localparam logic [15:0] POS_CAP = 16'hFFFF;
    localparam logic [14:0] LRUN_BASE = 15'h4000;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_PAL   = 2'd1,
        OP_START = 2'd2
    } op_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // span request from the parser, before the palette lookup
    typedef struct packed {
        logic        valid;
        logic [15:0] start;
        logic [13:0] len;
        logic        done;
    } span_t;

    typedef struct packed {
        logic [15:0] start;
        logic [13:0] len;
        rgb_t        rgb;
        logic        done;
    } out_t;

endpackage

/* rtl/anim_run_skip_dump_decoder.sv */
// channel   direction  beat
// s_*       in         operation, data byte, palette slot and colour
// m_*       out        span start, length, colour, record end flag
// cfg_*     in         frame size in pixels (17 bits)
//
// one input beat per cycle while s_ready is high; a span reaches m_* after the lookup stage
// the lookup stage holds the registered palette read, then comes a two-entry output buffer
// s_ready comes from registers; low only while lookup stage and output buffer all hold spans
// beats that give no span never wait on m_ready while the buffer has room
// synchronous reset clears the parser, palette valid bits and frame size (64000)
module anim_run_skip_dump_decoder
    import arsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_data_byte,
    input  logic [7:0]  s_palette_slot,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_start_position,
    output logic [13:0] m_span_length,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic        m_record_done,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    logic        s_fire;
    op_t         op;
    logic [16:0] frame_pixels_reg;
    span_t       span;
    rgb_t        pal_rgb;
    rgb_t        wr_rgb;

    logic        p1_valid_reg;
    span_t       p1_span_reg;
    out_t        p1_item;

    logic        out_valid_reg;
    out_t        out_reg;
    logic        skid_valid_reg;
    out_t        skid_reg;
    logic        push;
    logic        pop;

    assign op      = op_t'(s_operation);
    assign s_ready = !p1_valid_reg || !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign wr_rgb  = '{r: s_red_in, g: s_green_in, b: s_blue_in};

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pixels_reg <= FRAME_PIXELS_RST;
        end else if (cfg_valid && cfg_ready) begin
            frame_pixels_reg <= cfg_data;
        end
    end

    arsd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (s_fire),
        .op           (op),
        .data_byte    (s_data_byte),
        .frame_pixels (frame_pixels_reg),
        .span         (span)
    );

    arsd_palette u_palette (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_fire && (op == OP_PAL)),
        .wr_slot (s_palette_slot),
        .wr_rgb  (wr_rgb),
        .rd_en   (s_fire),
        .rd_slot (s_data_byte),
        .rd_rgb  (pal_rgb)
    );

    // lookup stage, waits with the palette read held while the buffer is full
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p1_valid_reg <= s_fire && span.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_span_reg <= span;
        end
    end

    always_comb begin
        p1_item.start = p1_span_reg.start;
        p1_item.len   = p1_span_reg.len;
        p1_item.done  = p1_span_reg.done;
        p1_item.rgb   = p1_span_reg.done ? '0 : pal_rgb;
    end

    assign push = p1_valid_reg && !skid_valid_reg;
    assign pop  = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (pop) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (push) begin
                out_valid_reg <= 1'b1;
                if (out_valid_reg && !pop) begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_reg <= p1_item;
            end else begin
                skid_reg <= p1_item;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_start_position = out_reg.start;
    assign m_span_length    = out_reg.len;
    assign m_red            = out_reg.rgb.r;
    assign m_green          = out_reg.rgb.g;
    assign m_blue           = out_reg.rgb.b;
    assign m_record_done    = out_reg.done;

endmodule

/* rtl/arsd_palette.sv */
module arsd_palette
    import arsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  logic [7:0] wr_slot,
    input  rgb_t       wr_rgb,
    input  logic       rd_en,
    input  logic [7:0] rd_slot,
    output rgb_t       rd_rgb
);

    rgb_t                   mem [PAL_DEPTH];
    logic [PAL_DEPTH-1:0]   written_reg;
    rgb_t                   rd_data_reg;
    logic                   rd_ok_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_slot] <= wr_rgb;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_slot];
        end
    end

    // entries never written read as black
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_slot] <= 1'b1;
            end
            if (rd_en) begin
                rd_ok_reg <= written_reg[rd_slot];
            end
        end
    end

    assign rd_rgb = rd_ok_reg ? rd_data_reg : '0;

endmodule

/* rtl/arsd_parser.sv */
module arsd_parser
    import arsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  op_t         op,
    input  logic [7:0]  data_byte,
    input  logic [16:0] frame_pixels,
    output span_t       span
);

    typedef enum logic [11:0] {
        PH_HDR0       = 12'b0000_0000_0001,
        PH_HDR1       = 12'b0000_0000_0010,
        PH_HDR2       = 12'b0000_0000_0100,
        PH_HDR3       = 12'b0000_0000_1000,
        PH_OPCODE     = 12'b0000_0001_0000,
        PH_DUMP       = 12'b0000_0010_0000,
        PH_SRUN_COUNT = 12'b0000_0100_0000,
        PH_SRUN_COLOR = 12'b0000_1000_0000,
        PH_LONG_LO    = 12'b0001_0000_0000,
        PH_LONG_HI    = 12'b0010_0000_0000,
        PH_LRUN_COLOR = 12'b0100_0000_0000,
        PH_DONE       = 12'b1000_0000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [16:0] pos_reg, pos_next;
    logic [14:0] remain_reg, remain_next;
    logic [7:0]  hold_reg, hold_next;

    logic [16:0] limit;
    logic [14:0] adv_amt;
    logic        adv_en;
    logic [17:0] adv_sum;
    logic [16:0] adv_pos;
    logic [13:0] emit_len;
    logic        emit_en;
    logic        done_en;
    logic [16:0] room;
    logic [13:0] clip_len;
    logic [14:0] dec_remain;
    logic [15:0] word;

    assign limit    = (frame_pixels > MAX_FRAME_PIXELS) ? MAX_FRAME_PIXELS : frame_pixels;
    assign adv_sum  = {1'b0, pos_reg} + {3'b000, adv_amt};
    assign adv_pos  = (adv_sum > {1'b0, MAX_FRAME_PIXELS}) ? MAX_FRAME_PIXELS : adv_sum[16:0];
    assign room     = limit - pos_reg;
    assign clip_len = ({3'b000, emit_len} > room) ? room[13:0] : emit_len;
    assign dec_remain = (remain_reg == '0) ? '0 : remain_reg - 15'd1;
    assign word     = {data_byte, hold_reg};

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        remain_next = remain_reg;
        hold_next   = hold_reg;
        adv_amt     = '0;
        adv_en      = 1'b0;
        emit_len    = '0;
        emit_en     = 1'b0;
        done_en     = 1'b0;
        span        = '0;

        if (step_en) begin
            unique case (op)
                OP_START: begin
                    phase_next  = PH_HDR0;
                    pos_next    = '0;
                    remain_next = '0;
                    hold_next   = '0;
                end
                OP_BYTE: begin
                    unique case (phase_reg)
                        PH_HDR0: phase_next = PH_HDR1;
                        PH_HDR1: phase_next = PH_HDR2;
                        PH_HDR2: phase_next = PH_HDR3;
                        PH_HDR3: phase_next = PH_OPCODE;
                        PH_OPCODE: begin
                            if (data_byte == 8'd0) begin
                                phase_next = PH_SRUN_COUNT;
                            end else if (!data_byte[7]) begin
                                remain_next = {7'd0, data_byte};
                                phase_next  = PH_DUMP;
                            end else if (data_byte[6:0] != 7'd0) begin
                                adv_en  = 1'b1;
                                adv_amt = {8'd0, data_byte[6:0]};
                            end else begin
                                phase_next = PH_LONG_LO;
                            end
                        end
                        PH_DUMP: begin
                            remain_next = dec_remain;
                            if (dec_remain == '0) begin
                                phase_next = PH_OPCODE;
                            end
                            emit_en  = 1'b1;
                            emit_len = 14'd1;
                        end
                        PH_SRUN_COUNT: begin
                            hold_next  = data_byte;
                            phase_next = PH_SRUN_COLOR;
                        end
                        PH_SRUN_COLOR: begin
                            phase_next = PH_OPCODE;
                            emit_en    = 1'b1;
                            emit_len   = {6'd0, hold_reg};
                        end
                        PH_LONG_LO: begin
                            hold_next  = data_byte;
                            phase_next = PH_LONG_HI;
                        end
                        PH_LONG_HI: begin
                            phase_next = PH_OPCODE;
                            if (word == 16'd0) begin
                                phase_next = PH_DONE;
                                done_en    = 1'b1;
                            end else if (!word[15]) begin
                                adv_en  = 1'b1;
                                adv_amt = word[14:0];
                            end else if (word[14:0] >= LRUN_BASE) begin
                                remain_next = word[14:0] - LRUN_BASE;
                                phase_next  = PH_LRUN_COLOR;
                            end else if (word[14:0] != 15'd0) begin
                                remain_next = word[14:0];
                                phase_next  = PH_DUMP;
                            end
                        end
                        PH_LRUN_COLOR: begin
                            phase_next = PH_OPCODE;
                            emit_en    = 1'b1;
                            emit_len   = remain_reg[13:0];
                        end
                        PH_DONE: phase_next = PH_DONE;
                        default: phase_next = phase_reg;
                    endcase
                end
                default: phase_next = phase_reg;
            endcase
        end

        if (emit_en) begin
            adv_en  = 1'b1;
            adv_amt = {1'b0, emit_len};
        end
        if (adv_en) begin
            pos_next = adv_pos;
        end

        if (emit_en && (emit_len != '0) && (pos_reg < limit)) begin
            span.valid = 1'b1;
            span.start = pos_reg[15:0];
            span.len   = clip_len;
        end else if (done_en) begin
            span.valid = 1'b1;
            span.start = pos_reg[16] ? POS_CAP : pos_reg[15:0];
            span.done  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            pos_reg    <= '0;
            remain_reg <= '0;
            hold_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            remain_reg <= remain_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

/* tb/anim_run_skip_dump_decoder_tb.sv */
module anim_run_skip_dump_decoder_tb
    import arsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QUIET_LIMIT  = 2000;
    localparam int          SETTLE       = 8;
    localparam int          MAX_WAIT     = 17;
    localparam int          RANDOM_BEATS = 1500;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [7:0]  OPC_RUN      = 8'h00;
    localparam logic [7:0]  LONG_FORM    = 8'h80;
    localparam logic [7:0]  SKIP_FLAG    = 8'h80;
    localparam logic [15:0] WORD_END     = 16'h0000;
    localparam logic [15:0] WORD_DUMP    = 16'h8000;
    localparam logic [15:0] WORD_LRUN    = 16'hC000;

    typedef enum logic [3:0] {
        PH_HDR0 = 4'd0,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_OPC,
        PH_DUMP,
        PH_SRUN_CNT,
        PH_SRUN_COL,
        PH_LONG_LO,
        PH_LONG_HI,
        PH_LRUN_COL,
        PH_DONE
    } parse_phase_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [7:0]  s_data_byte;
    logic [7:0]  s_palette_slot;
    logic [7:0]  s_red_in;
    logic [7:0]  s_green_in;
    logic [7:0]  s_blue_in;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_start_position;
    logic [13:0] m_span_length;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic        m_record_done;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;

    // decoder state as seen by the span predictor
    rgb_t         pal_mem [PAL_DEPTH];
    parse_phase_t phase;
    logic [16:0]  pos;
    logic [14:0]  remain;
    logic [7:0]   held;
    logic [16:0]  frame_size;

    out_t expected_spans [$];

    bit src_idle;
    bit sink_idle;
    int beats_sent;
    int records_run;
    int frames_set;
    int spans_seen;
    int ends_seen;
    int mismatches;

    anim_run_skip_dump_decoder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_data_byte      (s_data_byte),
        .s_palette_slot   (s_palette_slot),
        .s_red_in         (s_red_in),
        .s_green_in       (s_green_in),
        .s_blue_in        (s_blue_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_start_position (m_start_position),
        .m_span_length    (m_span_length),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue),
        .m_record_done    (m_record_done),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_wait(input bit idling);
        return idling ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    function automatic void clear_parser();
        phase  = PH_HDR0;
        pos    = '0;
        remain = '0;
        held   = '0;
    endfunction

    function automatic void step_position(input int n);
        int p;
        p = int'(pos) + n;
        if (p > int'(MAX_FRAME_PIXELS))
            p = int'(MAX_FRAME_PIXELS);
        pos = p[16:0];
    endfunction

    function automatic bit clip_span(input int len, input logic [7:0] idx, output out_t sp);
        int lim;
        int at;
        lim = (frame_size > MAX_FRAME_PIXELS) ? int'(MAX_FRAME_PIXELS) : int'(frame_size);
        at  = int'(pos);
        sp  = '0;
        step_position(len);
        if (len == 0 || at >= lim)
            return 1'b0;
        if (len > lim - at)
            len = lim - at;
        sp.start = at[15:0];
        sp.len   = len[13:0];
        sp.rgb   = pal_mem[idx];
        sp.done  = 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_beat(input logic [1:0] op, input logic [7:0] d,
                                         input logic [7:0] slot, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b);
        out_t        sp;
        logic [15:0] word;
        bit          made;
        made = 1'b0;
        sp   = '0;
        case (op)
            OP_PAL: pal_mem[slot] = rgb_t'({r, g, b});
            OP_START: clear_parser();
            OP_BYTE: begin
                case (phase)
                    PH_OPC: begin
                        if (!d[7] && d != OPC_RUN) begin
                            remain = {7'd0, d};
                            phase  = PH_DUMP;
                        end else if (d == OPC_RUN) begin
                            phase = PH_SRUN_CNT;
                        end else if (d[6:0] != 7'd0) begin
                            step_position(int'(d[6:0]));
                        end else begin
                            phase = PH_LONG_LO;
                        end
                    end
                    PH_DUMP: begin
                        if (remain != 0)
                            remain = remain - 15'd1;
                        if (remain == 0)
                            phase = PH_OPC;
                        made = clip_span(1, d, sp);
                    end
                    PH_SRUN_CNT: begin
                        held  = d;
                        phase = PH_SRUN_COL;
                    end
                    PH_SRUN_COL: begin
                        phase = PH_OPC;
                        made  = clip_span(int'(held), d, sp);
                    end
                    PH_LONG_LO: begin
                        held  = d;
                        phase = PH_LONG_HI;
                    end
                    PH_LONG_HI: begin
                        word  = {d, held};
                        phase = PH_OPC;
                        if (word == WORD_END) begin
                            phase    = PH_DONE;
                            sp.start = (pos > POS_CAP) ? POS_CAP : pos[15:0];
                            sp.len   = '0;
                            sp.rgb   = '0;
                            sp.done  = 1'b1;
                            made     = 1'b1;
                        end else if (!word[15]) begin
                            step_position(int'(word));
                        end else if (word[14]) begin
                            remain = {1'b0, word[13:0]};
                            phase  = PH_LRUN_COL;
                        end else if (word[13:0] != 14'd0) begin
                            remain = {1'b0, word[13:0]};
                            phase  = PH_DUMP;
                        end
                    end
                    PH_LRUN_COL: begin
                        phase = PH_OPC;
                        made  = clip_span(int'(remain[13:0]), d, sp);
                    end
                    PH_DONE: ;
                    default: begin
                        phase = (phase == PH_HDR3) ? PH_OPC : parse_phase_t'(phase + 4'd1);
                    end
                endcase
            end
            default: ;
        endcase
        if (made)
            expected_spans.push_back(sp);
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [7:0] d, input logic [7:0] slot,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = pick_wait(src_idle);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_data_byte    <= d;
        s_palette_slot <= slot;
        s_red_in       <= r;
        s_green_in     <= g;
        s_blue_in      <= b;
        do @(posedge aclk); while (!s_ready);
        predict_beat(op, d, slot, r, g, b);
        beats_sent++;
    endtask

    task automatic rec_byte(input logic [7:0] d);
        send_beat(OP_BYTE, d, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic rec_word(input logic [15:0] w);
        rec_byte(w[7:0]);
        rec_byte(w[15:8]);
    endtask

    task automatic rec_start();
        send_beat(OP_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic pal_write(input logic [7:0] slot, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        send_beat(OP_PAL, 8'($urandom), slot, r, g, b);
    endtask

    // drop valid, let every span drain, then give the pipeline time to settle
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_frame(input logic [16:0] v);
        quiesce();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        frame_size = v;
        frames_set++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random back-pressure and comparison against the oldest span
    initial begin
        out_t got;
        out_t want;
        bit   took;
        int   stall;
        m_ready = 1'b0;
        stall   = 0;
        forever begin
            @(posedge aclk);
            took = aresetn && m_valid && m_ready;
            if (took) begin
                got.start = m_start_position;
                got.len   = m_span_length;
                got.rgb   = rgb_t'({m_red, m_green, m_blue});
                got.done  = m_record_done;
                if (got.done)
                    ends_seen++;
                else
                    spans_seen++;
                if (expected_spans.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: start %0d len %0d rgb %06h done %0b",
                                 got.start, got.len, got.rgb, got.done);
                end else begin
                    want = expected_spans.pop_front();
                    if (got.start !== want.start || got.len !== want.len ||
                        got.rgb !== want.rgb || got.done !== want.done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("span mismatch: expected start %0d len %0d rgb %06h",
                                     want.start, want.len, want.rgb,
                                     " done %0b, got start %0d len %0d rgb %06h done %0b",
                                     want.done, got.start, got.len, got.rgb, got.done);
                    end
                end
            end
            @(negedge aclk);
            if (took)
                stall = pick_wait(sink_idle);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("anim_run_skip_dump_decoder_tb: done, errors");
        $finish;
    end

    task automatic test_palette_extremes();
        pal_write(8'h00, 8'hFF, 8'h00, 8'hFF);
        pal_write(8'hFF, 8'h00, 8'hFF, 8'h00);
    endtask

    // one record through every opcode, with the frame cut at 40000 so the long run is clipped
    task automatic test_record_forms();
        set_frame(17'd40000);
        rec_start();
        repeat (2) begin
            rec_byte(8'hFF);
            rec_byte(8'h00);
        end
        rec_byte(8'h01);
        rec_byte(8'hFF);
        rec_byte(OPC_RUN);
        rec_byte(8'hFF);
        rec_byte(8'h00);
        rec_byte(OPC_RUN);
        rec_byte(8'h00);
        rec_byte(8'h01);
        rec_byte(SKIP_FLAG | 8'h7F);
        send_beat(OP_UNUSED, 8'h00, 8'h01, 8'hAA, 8'h55, 8'hFF);
        rec_byte(LONG_FORM);
        rec_word(16'h7FFF);
        rec_byte(LONG_FORM);
        rec_word(16'hFFFF);
        rec_byte(8'hFF);
        rec_byte(LONG_FORM);
        rec_word(WORD_DUMP);
        rec_byte(LONG_FORM);
        rec_word(WORD_DUMP | 16'd1);
        rec_byte(8'h00);
        // position saturates at the frame buffer ceiling
        rec_byte(LONG_FORM);
        rec_word(16'h7FFF);
        rec_byte(LONG_FORM);
        rec_word(WORD_END);
        rec_byte(8'h01);
        records_run++;
    endtask

    task automatic test_frame_extremes();
        set_frame(17'd0);
        rec_start();
        repeat (4) rec_byte(8'h00);
        rec_byte(8'h01);
        rec_byte(8'hFF);
        set_frame(17'd1);
        rec_start();
        repeat (4) rec_byte(8'h00);
        rec_byte(OPC_RUN);
        rec_byte(8'h03);
        rec_byte(8'hFF);
        set_frame(MAX_FRAME_PIXELS);
        records_run += 2;
    endtask

    task automatic random_record();
        int          n;
        logic [15:0] w;
        src_idle  = $urandom_range(0, 3) != 0;
        sink_idle = $urandom_range(0, 3) != 0;
        rec_start();
        repeat (4) rec_byte(8'($urandom));
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 9))
                2: begin
                    rec_byte(OPC_RUN);
                    rec_byte(8'($urandom));
                    rec_byte(8'($urandom));
                end
                3: rec_byte(SKIP_FLAG | 8'($urandom_range(1, 127)));
                4: begin
                    w = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 16'h7FFF))
                                                    : 16'($urandom_range(1, 2000));
                    rec_byte(LONG_FORM);
                    rec_word(w);
                end
                5: begin
                    rec_byte(LONG_FORM);
                    rec_word(WORD_LRUN | 16'($urandom_range(0, 16383)));
                    rec_byte(8'($urandom));
                end
                6: begin
                    n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300)
                                                     : $urandom_range(0, 8);
                    rec_byte(LONG_FORM);
                    rec_word(WORD_DUMP | 16'(n));
                    repeat (n) rec_byte(8'($urandom));
                end
                7: pal_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                8: send_beat(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom));
                default: begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127)
                                                    : $urandom_range(1, 6);
                    rec_byte(8'(n));
                    repeat (n) rec_byte(8'($urandom));
                end
            endcase
        end
        // most records end properly, some are cut off by the next start
        if ($urandom_range(0, 7) != 0) begin
            rec_byte(LONG_FORM);
            rec_word(WORD_END);
            repeat ($urandom_range(0, 2)) rec_byte(8'($urandom));
        end
        records_run++;
    endtask

    task automatic test_random_records();
        int target;
        target = beats_sent + RANDOM_BEATS;
        repeat (32) pal_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        while (beats_sent < target) begin
            if (records_run % 6 == 0) begin
                case ($urandom_range(0, 5))
                    0: set_frame(MAX_FRAME_PIXELS);
                    1: set_frame(FRAME_PIXELS_RST);
                    2: set_frame(17'd1);
                    3: set_frame(17'($urandom_range(1, 65536)));
                    4: set_frame(17'($urandom_range(1, 2000)));
                    default: set_frame(17'($urandom_range(60000, 65536)));
                endcase
            end
            random_record();
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = OP_BYTE;
        s_data_byte    = '0;
        s_palette_slot = '0;
        s_red_in       = '0;
        s_green_in     = '0;
        s_blue_in      = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        src_idle       = 1'b0;
        sink_idle      = 1'b0;
        beats_sent     = 0;
        records_run    = 0;
        frames_set     = 0;
        spans_seen     = 0;
        ends_seen      = 0;
        mismatches     = 0;
        foreach (pal_mem[i])
            pal_mem[i] = '0;
        clear_parser();
        frame_size = FRAME_PIXELS_RST;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_palette_extremes();
        test_record_forms();
        test_frame_extremes();
        test_random_records();
        quiesce();

        $display("sent %0d input beats across %0d records under %0d frame size settings",
                 beats_sent, records_run, frames_set);
        $display("received %0d spans and %0d record ends, %0d mismatches",
                 spans_seen, ends_seen, mismatches);
        if (mismatches == 0)
            $display("anim_run_skip_dump_decoder_tb: done, clean");
        else
            $display("anim_run_skip_dump_decoder_tb: done, errors");
        $finish;
    end

endmodule
